@@ design/edf_pkg.sv @@
package edf_pkg;

    localparam int unsigned MAX_TASKS       = 4;
    localparam int unsigned DEF_TASK_COUNT  = 4;
    localparam int unsigned TASK_IDX_W      = 2;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned RUN_W           = 3;
    localparam int unsigned CFG_IDX_W       = 3;

    localparam logic [RUN_W-1:0]  IDLE_CODE  = 3'd4;
    localparam logic              CFG_PERIOD = 1'b0;
    localparam logic              CFG_BURST  = 1'b1;
    localparam logic [BYTE_W-1:0] PERIOD_RST = 8'd1;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

    typedef logic [MAX_TASKS-1:0][BYTE_W-1:0] t_byte_vec;
    typedef logic [MAX_TASKS-1:0][CNT_W-1:0]  t_cnt_vec;

    typedef struct packed {
        logic                  busy;
        logic [TASK_IDX_W-1:0] idx;
    } t_pick;

    function automatic logic [BYTE_W-1:0] load_period(input logic [BYTE_W-1:0] p);
        load_period = (p == '0) ? PERIOD_RST : p;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ design/edf_pick.sv @@
module edf_pick
    import edf_pkg::*;
#(
    parameter int unsigned TASK_COUNT = DEF_TASK_COUNT
) (
    input  t_byte_vec i_time_left,
    input  t_byte_vec i_work_left,
    output t_pick     o_pick
);

    logic [BYTE_W-1:0] best;

    always_comb begin
        o_pick = '0;
        best   = '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            if ((k < TASK_COUNT) && (i_work_left[k] != '0)) begin
                if (!o_pick.busy || (i_time_left[k] < best)) begin
                    o_pick.busy = 1'b1;
                    o_pick.idx  = TASK_IDX_W'(k);
                    best        = i_time_left[k];
                end
            end
        end
    end

endmodule

@@ design/edf_task_bank.sv @@
module edf_task_bank
    import edf_pkg::*;
#(
    parameter int unsigned TASK_COUNT = DEF_TASK_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_step,
    input  t_pick                i_pick,
    output t_byte_vec            o_time_left,
    output t_byte_vec            o_work_left,
    output logic                 o_job_done,
    output logic [MAX_TASKS-1:0] o_miss_mask,
    output t_cnt_vec             o_done_next,
    output t_cnt_vec             o_miss_next
);

    t_byte_vec r_period, n_period;
    t_byte_vec r_burst, n_burst;
    t_byte_vec r_ttr, n_ttr;
    t_byte_vec r_wl, n_wl;
    t_cnt_vec  r_done, n_done;
    t_cnt_vec  r_miss, n_miss;

    logic [MAX_TASKS-1:0] fin;
    logic [BYTE_W-1:0]    wl_run;
    logic [BYTE_W-1:0]    t_dec;
    logic                 ran;
    logic                 adv;
    logic                 rel;
    logic                 cfg_hit;

    always_comb begin
        n_period    = r_period;
        n_burst     = r_burst;
        n_ttr       = r_ttr;
        n_wl        = r_wl;
        n_done      = r_done;
        n_miss      = r_miss;
        fin         = '0;
        o_miss_mask = '0;
        wl_run      = '0;
        t_dec       = '0;
        ran         = 1'b0;
        adv         = 1'b0;
        rel         = 1'b0;
        cfg_hit     = 1'b0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            cfg_hit = i_cfg_we && (i_cfg_index[CFG_IDX_W-1:1] == TASK_IDX_W'(k));
            adv     = i_step && (k < TASK_COUNT);
            ran     = adv && i_pick.busy && (i_pick.idx == TASK_IDX_W'(k));
            wl_run  = ran ? r_wl[k] - 1'b1 : r_wl[k];
            fin[k]  = ran && (wl_run == '0);
            t_dec   = (r_ttr[k] == '0) ? '0 : r_ttr[k] - 1'b1;
            rel     = adv && (t_dec == '0);
            if (fin[k]) begin
                n_done[k] = sat_inc(r_done[k]);
            end
            if (rel && (wl_run != '0)) begin
                o_miss_mask[k] = 1'b1;
                n_miss[k]      = sat_inc(r_miss[k]);
            end
            if (adv) begin
                n_ttr[k] = rel ? load_period(r_period[k]) : t_dec;
                n_wl[k]  = rel ? r_burst[k] : wl_run;
            end
            if (cfg_hit && (i_cfg_index[0] == CFG_PERIOD)) begin
                n_period[k] = i_cfg_data;
                n_ttr[k]    = load_period(i_cfg_data);
            end
            if (cfg_hit && (i_cfg_index[0] == CFG_BURST)) begin
                n_burst[k] = i_cfg_data;
                n_wl[k]    = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= {MAX_TASKS{PERIOD_RST}};
            r_burst  <= '0;
            r_ttr    <= {MAX_TASKS{PERIOD_RST}};
            r_wl     <= '0;
            r_done   <= '0;
            r_miss   <= '0;
        end else begin
            r_period <= n_period;
            r_burst  <= n_burst;
            r_ttr    <= n_ttr;
            r_wl     <= n_wl;
            r_done   <= n_done;
            r_miss   <= n_miss;
        end
    end

    assign o_time_left = r_ttr;
    assign o_work_left = r_wl;
    assign o_job_done  = |fin;
    assign o_done_next = n_done;
    assign o_miss_next = n_miss;

endmodule

@@ design/edf_tick_scheduler_top.sv @@
// An accepted request passes through the input register and then the result register to its result.
// One request per cycle while o_in_stall is low; the next task state is computed combinationally.
// A request with tick low is taken but yields no result and leaves the state unchanged.
// Reset (i_rst_n low, synchronous): periods 1, bursts 0, task bank counters 0, pipeline empty.
module edf_tick_scheduler_top
    import edf_pkg::*;
#(
    parameter int unsigned TASK_COUNT = DEF_TASK_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_tick,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [RUN_W-1:0]     o_running_task,
    output logic                 o_job_done,
    output logic [MAX_TASKS-1:0] o_miss_mask,
    output logic [CNT_W-1:0]     o_done_count_0,
    output logic [CNT_W-1:0]     o_done_count_1,
    output logic [CNT_W-1:0]     o_done_count_2,
    output logic [CNT_W-1:0]     o_done_count_3,
    output logic [CNT_W-1:0]     o_miss_count_0,
    output logic [CNT_W-1:0]     o_miss_count_1,
    output logic [CNT_W-1:0]     o_miss_count_2,
    output logic [CNT_W-1:0]     o_miss_count_3,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic                 r_s1_valid;
    logic                 r_s1_tick;
    logic                 r_out_valid;
    logic [RUN_W-1:0]     r_run;
    logic                 r_done;
    logic [MAX_TASKS-1:0] r_miss;
    t_cnt_vec             r_done_cnt;
    t_cnt_vec             r_miss_cnt;

    logic                 s1_advance;
    logic                 step;
    t_pick                pick;
    t_byte_vec            time_left;
    t_byte_vec            work_left;
    logic                 job_done;
    logic [MAX_TASKS-1:0] miss_mask;
    t_cnt_vec             done_next;
    t_cnt_vec             miss_next;

    assign s1_advance = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign step       = r_s1_valid && r_s1_tick && s1_advance;

    edf_pick #(
        .TASK_COUNT(TASK_COUNT)
    ) u_pick (
        .i_time_left(time_left),
        .i_work_left(work_left),
        .o_pick     (pick)
    );

    edf_task_bank #(
        .TASK_COUNT(TASK_COUNT)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_pick     (pick),
        .o_time_left(time_left),
        .o_work_left(work_left),
        .o_job_done (job_done),
        .o_miss_mask(miss_mask),
        .o_done_next(done_next),
        .o_miss_next(miss_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid && r_s1_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_tick <= i_tick;
        end
        if (step) begin
            r_run      <= pick.busy ? RUN_W'(pick.idx) : IDLE_CODE;
            r_done     <= job_done;
            r_miss     <= miss_mask;
            r_done_cnt <= done_next;
            r_miss_cnt <= miss_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_running_task = r_run;
    assign o_job_done     = r_done;
    assign o_miss_mask    = r_miss;
    assign o_done_count_0 = r_done_cnt[0];
    assign o_done_count_1 = r_done_cnt[1];
    assign o_done_count_2 = r_done_cnt[2];
    assign o_done_count_3 = r_done_cnt[3];
    assign o_miss_count_0 = r_miss_cnt[0];
    assign o_miss_count_1 = r_miss_cnt[1];
    assign o_miss_count_2 = r_miss_cnt[2];
    assign o_miss_count_3 = r_miss_cnt[3];

`ifndef SYNTH
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_running_task == IDLE_CODE)) |-> !o_job_done)
        else $error("job completion reported on an idle tick");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result register can drain");

    a_step_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("scheduled tick produced no result");
`endif

endmodule
